>>> src/v3au_pkg.sv
`timescale 1ns / 1ps
// v3au_pkg: shared constants, codes, types and rounding helpers for the
// 3D vector ALU. No dependencies.
package v3au_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NW        = 32 + FRAC_BITS;   // scaled dividend width
	localparam int SQ_STEPS  = 32;               // one root bit per stage
	localparam int DIV_STEPS = 32;               // one quotient bit per stage
	localparam int DIV_DEPTH = DIV_STEPS + 1;    // setup stage plus steps

	typedef logic [2:0]         kind_t;
	typedef logic signed [31:0] word_t;

	localparam kind_t K_ADD   = 3'd0;
	localparam kind_t K_SUB   = 3'd1;
	localparam kind_t K_SCALE = 3'd2;
	localparam kind_t K_DIV   = 3'd3;
	localparam kind_t K_DOT   = 3'd4;
	localparam kind_t K_CROSS = 3'd5;
	localparam kind_t K_MAG   = 3'd6;
	localparam kind_t K_NORM  = 3'd7;

	localparam word_t SMAX = 32'sh7fffffff;
	localparam word_t SMIN = 32'sh80000000;

	localparam logic signed [65:0] HALF66 = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] MAX66  = 66'sd2147483647;
	localparam logic signed [65:0] MIN66  = -66'sd2147483648;

	// item state that rides along the root pipeline
	typedef struct packed {
		kind_t            kind;
		logic [2:0][31:0] r;
		logic [31:0]      rs;
		logic [2:0][31:0] amag;
		logic [2:0]       aneg;
		logic [31:0]      s;
	} side_t;

	// item state that rides along the divider pipeline
	typedef struct packed {
		kind_t            kind;
		logic [2:0][31:0] r;
		logic [31:0]      rs;
		logic             zden;
	} side2_t;

	// round a wide product sum to nearest (ties up), then saturate
	function automatic word_t fx_round(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = (v + HALF66) >>> FRAC_BITS;
		if (t > MAX66) return SMAX;
		if (t < MIN66) return SMIN;
		return word_t'(t[31:0]);
	endfunction

	function automatic word_t sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) return v[32] ? SMIN : SMAX;
		return word_t'(v[31:0]);
	endfunction

endpackage

>>> src/v3au_lane.sv
`timescale 1ns / 1ps
// v3au_lane: one component lane, stages s1..s3: add/sub, the two lane
// products, difference and rounding. Depends on v3au_pkg.
module v3au_lane import v3au_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  kind_t               kind,
	input  kind_t               kind_s1,
	input  kind_t               kind_s2,
	input  word_t               a_i,
	input  word_t               b_i,
	input  word_t               a_j,
	input  word_t               b_j,
	input  word_t               a_k,
	input  word_t               b_k,
	input  word_t               s,
	output logic signed [63:0]  p0_s1,
	output word_t               r_s3,
	output logic [31:0]         amag_s3,
	output logic                aneg_s3
);

	word_t              m0a, m0b;
	logic signed [32:0] as_sum;
	logic signed [63:0] p1_s1;
	word_t              as_s1, as_s2, a_s1, a_s2;
	logic signed [65:0] d_s2;

	always_comb begin
		m0a = (kind == K_CROSS) ? a_j : a_i;
		case (kind)
			K_SCALE: m0b = s;
			K_DOT:   m0b = b_i;
			K_CROSS: m0b = b_k;
			default: m0b = a_i;
		endcase
		if (kind == K_SUB)
			as_sum = 33'(a_i) - 33'(b_i);
		else
			as_sum = 33'(a_i) + 33'(b_i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= 64'(m0a) * 64'(m0b);
			p1_s1 <= 64'(a_k) * 64'(b_j);
			as_s1 <= sat33(as_sum);
			a_s1  <= a_i;
			// cross term is a difference, everything else a single product
			d_s2  <= (kind_s1 == K_CROSS) ? 66'(p0_s1) - 66'(p1_s1) : 66'(p0_s1);
			as_s2 <= as_s1;
			a_s2  <= a_s1;
			case (kind_s2)
				K_ADD, K_SUB:     r_s3 <= as_s2;
				K_SCALE, K_CROSS: r_s3 <= fx_round(d_s2);
				default:          r_s3 <= '0;
			endcase
			amag_s3 <= a_s2[31] ? 32'(-a_s2) : 32'(a_s2);
			aneg_s3 <= a_s2[31];
		end
	end

endmodule

>>> src/v3au_merge.sv
`timescale 1ns / 1ps
// v3au_merge: combines the three lane products into the dot product and
// the sum of squares (stages s2, s3). Depends on v3au_pkg.
module v3au_merge import v3au_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] p_x,
	input  logic signed [63:0] p_y,
	input  logic signed [63:0] p_z,
	output word_t              dot_s3,
	output logic [63:0]        sq_s3
);

	logic signed [65:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= 66'(p_x) + 66'(p_y) + 66'(p_z);
			dot_s3 <= fx_round(sum_s2);
			sq_s3  <= sum_s2[63:0];   // squares: nonnegative, below 2^64
		end
	end

endmodule

>>> src/v3au_sqrt.sv
`timescale 1ns / 1ps
// v3au_sqrt: pipelined restoring square root, one root bit per stage,
// carrying item valid and side data. Depends on v3au_pkg.
module v3au_sqrt import v3au_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [63:0] rad_in,
	input  side_t       side_in,
	output logic        vld_out,
	output logic [31:0] root_out,
	output logic [33:0] rem_out,
	output side_t       side_out
);

	logic [31:0] root_s [SQ_STEPS];
	logic [33:0] rem_s  [SQ_STEPS];
	logic [63:0] rad_s  [SQ_STEPS];
	side_t       side_s [SQ_STEPS];
	logic        vld_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [31:0] root_p;
		logic [33:0] rem_p;
		logic [63:0] rad_p;
		side_t       side_p;
		logic        vld_p;
		logic [35:0] t, trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign root_p = '0;
			assign rem_p  = '0;
			assign rad_p  = rad_in;
			assign side_p = side_in;
			assign vld_p  = vld_in;
		end else begin : g_next
			assign root_p = root_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		always_comb begin
			t     = {rem_p, rad_p[63:62]};
			trial = {2'b00, root_p, 2'b01};
			ge    = (t >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? 34'(t - trial) : 34'(t);
				root_s[k] <= {root_p[30:0], ge};
				rad_s[k]  <= rad_p << 2;
				side_s[k] <= side_p;
			end
		end
	end

	assign vld_out  = vld_s[SQ_STEPS-1];
	assign root_out = root_s[SQ_STEPS-1];
	assign rem_out  = rem_s[SQ_STEPS-1];
	assign side_out = side_s[SQ_STEPS-1];

endmodule

>>> src/v3au_div.sv
`timescale 1ns / 1ps
// v3au_div: pipelined restoring divider for one lane, round(|a|*2^F/den)
// with ties away from zero, signed and saturated. Depends on v3au_pkg.
module v3au_div import v3au_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] amag,
	input  logic        aneg,
	input  logic [31:0] den,
	input  logic        den_neg,
	output word_t       q
);

	logic [NW-1:0] num;
	logic [32:0]   rem_s [DIV_DEPTH];
	logic [31:0]   lo_s  [DIV_DEPTH];
	logic [31:0]   quo_s [DIV_DEPTH];
	logic [31:0]   den_s [DIV_DEPTH];
	logic          neg_s [DIV_DEPTH];
	logic          ovf_s [DIV_DEPTH];
	logic [31:0]   qf;

	// half the divisor is added up front so the floor quotient rounds
	assign num = (NW'(amag) << FRAC_BITS) + NW'(den >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 33'(num[NW-1:32]);
			lo_s[0]  <= num[31:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= aneg ^ den_neg;
			ovf_s[0] <= (32'(num[NW-1:32]) >= den);  // quotient needs 33+ bits
		end
	end

	for (genvar k = 1; k < DIV_DEPTH; k++) begin : g_step
		logic [32:0] t;
		logic        ge;

		always_comb begin
			t  = {rem_s[k-1][31:0], lo_s[k-1][31]};
			ge = (t >= {1'b0, den_s[k-1]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? t - {1'b0, den_s[k-1]} : t;
				lo_s[k]  <= lo_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][30:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign qf = quo_s[DIV_DEPTH-1];

	always_comb begin
		if (ovf_s[DIV_DEPTH-1])
			q = neg_s[DIV_DEPTH-1] ? SMIN : SMAX;
		else if (neg_s[DIV_DEPTH-1])
			q = (qf > 32'h80000000) ? SMIN : word_t'(-qf);
		else
			q = qf[31] ? SMAX : word_t'(qf);
	end

endmodule

>>> src/vector3_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// vector3_arithmetic_unit_core: top level of the 3D vector ALU.
// Depends on v3au_pkg, v3au_lane, v3au_merge, v3au_sqrt, v3au_div.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | kind, a_x a_y a_z, b_x b_y b_z, scalar_in
//  out     | out_valid / out_ready| r_x r_y r_z, r_scalar, error
//
// One beat per cycle in, one per cycle out while out_ready stays high;
// every kind takes the same path: products, lane merge, rounding, the 32
// root stages, root rounding and divisor select, the 33 divider stages
// (setup and quotient bits) and the output register.
// arst_n clears every valid bit and the output/skid slots; data regs are
// not reset. A stalled output parks one beat in the skid slot; in_ready is
// low only while that slot is full, and the whole pipe then freezes.
module vector3_arithmetic_unit_core import v3au_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  kind_t kind,
	input  word_t a_x,
	input  word_t a_y,
	input  word_t a_z,
	input  word_t b_x,
	input  word_t b_y,
	input  word_t b_z,
	input  word_t scalar_in,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t r_x,
	output word_t r_y,
	output word_t r_z,
	output word_t r_scalar,
	output logic  error
);

	logic adv;                         // whole pipe advances

	// front stages
	logic  vld_s1, vld_s2, vld_s3;
	kind_t kind_s1, kind_s2, kind_s3;
	word_t s_s1, s_s2, s_s3;

	logic signed [63:0] p0_s1 [3];
	word_t              r_s3  [3];
	logic [31:0]        amag_s3 [3];
	logic               aneg_s3 [3];
	word_t              dot_s3;
	logic [63:0]        sq_s3;

	// root pipeline
	side_t       side_in, side_sq;
	logic        vld_sq;
	logic [31:0] root_sq;
	logic [33:0] rem_sq;

	// post-root stage
	logic [32:0]      mag_r;
	logic             vld_s4;
	side2_t           side_s4;
	logic [31:0]      den_s4;
	logic             den_neg_s4;
	logic [2:0][31:0] amag_s4;
	logic [2:0]       aneg_s4;

	// divider-aligned delay line
	logic   vld_d  [DIV_DEPTH];
	side2_t side_d [DIV_DEPTH];
	word_t  q [3];

	// result and output slots
	logic   p_take;
	side2_t sd;
	word_t  p_x, p_y, p_z, p_s;
	logic   p_err;
	logic   ov_q, sk_q;
	word_t  sk_x_q, sk_y_q, sk_z_q, sk_s_q;
	logic   sk_err_q;
	logic   out_free;

	assign adv      = !sk_q;
	assign in_ready = adv;

	// ---- stages s1..s3: lanes and merge ----
	v3au_lane u_lane_x (
		.clk, .en(adv), .kind, .kind_s1, .kind_s2,
		.a_i(a_x), .b_i(b_x), .a_j(a_y), .b_j(b_y), .a_k(a_z), .b_k(b_z),
		.s(scalar_in), .p0_s1(p0_s1[0]), .r_s3(r_s3[0]),
		.amag_s3(amag_s3[0]), .aneg_s3(aneg_s3[0])
	);
	v3au_lane u_lane_y (
		.clk, .en(adv), .kind, .kind_s1, .kind_s2,
		.a_i(a_y), .b_i(b_y), .a_j(a_z), .b_j(b_z), .a_k(a_x), .b_k(b_x),
		.s(scalar_in), .p0_s1(p0_s1[1]), .r_s3(r_s3[1]),
		.amag_s3(amag_s3[1]), .aneg_s3(aneg_s3[1])
	);
	v3au_lane u_lane_z (
		.clk, .en(adv), .kind, .kind_s1, .kind_s2,
		.a_i(a_z), .b_i(b_z), .a_j(a_x), .b_j(b_x), .a_k(a_y), .b_k(b_y),
		.s(scalar_in), .p0_s1(p0_s1[2]), .r_s3(r_s3[2]),
		.amag_s3(amag_s3[2]), .aneg_s3(aneg_s3[2])
	);

	v3au_merge u_merge (
		.clk, .en(adv), .p_x(p0_s1[0]), .p_y(p0_s1[1]), .p_z(p0_s1[2]),
		.dot_s3, .sq_s3
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			s_s1    <= scalar_in;
			s_s2    <= s_s1;
			s_s3    <= s_s2;
		end
	end

	// ---- root pipeline: sum of squares -> floor root and remainder ----
	always_comb begin
		side_in.kind = kind_s3;
		side_in.r    = {r_s3[2], r_s3[1], r_s3[0]};
		side_in.rs   = (kind_s3 == K_DOT) ? dot_s3 : '0;
		side_in.amag = {amag_s3[2], amag_s3[1], amag_s3[0]};
		side_in.aneg = {aneg_s3[2], aneg_s3[1], aneg_s3[0]};
		side_in.s    = s_s3;
	end

	v3au_sqrt u_sqrt (
		.clk, .arst_n, .en(adv), .vld_in(vld_s3), .rad_in(sq_s3),
		.side_in, .vld_out(vld_sq), .root_out(root_sq), .rem_out(rem_sq),
		.side_out(side_sq)
	);

	// ---- s4: round root, pick divisor ----
	// remainder above the floor root means the true root is past the midpoint
	assign mag_r = {1'b0, root_sq} + 33'(rem_sq > {2'b00, root_sq});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (adv)
			vld_s4 <= vld_sq;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.kind <= side_sq.kind;
			side_s4.r    <= side_sq.r;
			if (side_sq.kind == K_MAG)
				side_s4.rs <= mag_r[31] ? 32'(SMAX) : mag_r[31:0];
			else
				side_s4.rs <= side_sq.rs;
			if (side_sq.kind == K_DIV) begin
				den_s4       <= side_sq.s[31] ? 32'(-side_sq.s) : side_sq.s;
				den_neg_s4   <= side_sq.s[31];
				side_s4.zden <= (side_sq.s == '0);
			end else begin
				den_s4       <= mag_r[31:0];
				den_neg_s4   <= 1'b0;
				side_s4.zden <= (mag_r == '0);
			end
			amag_s4 <= side_sq.amag;
			aneg_s4 <= side_sq.aneg;
		end
	end

	// ---- divider lanes and the matching delay line ----
	for (genvar i = 0; i < 3; i++) begin : g_div
		v3au_div u_div (
			.clk, .en(adv), .amag(amag_s4[i]), .aneg(aneg_s4[i]),
			.den(den_s4), .den_neg(den_neg_s4), .q(q[i])
		);
	end

	for (genvar k = 0; k < DIV_DEPTH; k++) begin : g_dly
		logic   vld_p;
		side2_t side_p;
		if (k == 0) begin : g_first
			assign vld_p  = vld_s4;
			assign side_p = side_s4;
		end else begin : g_next
			assign vld_p  = vld_d[k-1];
			assign side_p = side_d[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_d[k] <= 1'b0;
			else if (adv)
				vld_d[k] <= vld_p;
		end
		always_ff @(posedge clk) begin
			if (adv)
				side_d[k] <= side_p;
		end
	end

	// ---- final select ----
	assign sd     = side_d[DIV_DEPTH-1];
	assign p_take = adv && vld_d[DIV_DEPTH-1];

	always_comb begin
		p_x   = word_t'(sd.r[0]);
		p_y   = word_t'(sd.r[1]);
		p_z   = word_t'(sd.r[2]);
		p_s   = word_t'(sd.rs);
		p_err = 1'b0;
		case (sd.kind)
			K_DIV, K_NORM: begin
				// zero divisor: zeros; flagged only for divide
				p_x   = sd.zden ? '0 : q[0];
				p_y   = sd.zden ? '0 : q[1];
				p_z   = sd.zden ? '0 : q[2];
				p_s   = '0;
				p_err = sd.zden && (sd.kind == K_DIV);
			end
			default: begin
			end
		endcase
	end

	// ---- output register with one-beat skid ----
	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_q <= 1'b0;
		end else if (out_free) begin
			if (sk_q) begin
				ov_q <= 1'b1;
				sk_q <= 1'b0;
			end else begin
				ov_q <= p_take;
			end
		end else if (p_take) begin
			sk_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (sk_q) begin
				r_x      <= sk_x_q;
				r_y      <= sk_y_q;
				r_z      <= sk_z_q;
				r_scalar <= sk_s_q;
				error    <= sk_err_q;
			end else if (p_take) begin
				r_x      <= p_x;
				r_y      <= p_y;
				r_z      <= p_z;
				r_scalar <= p_s;
				error    <= p_err;
			end
		end else if (p_take) begin
			sk_x_q   <= p_x;
			sk_y_q   <= p_y;
			sk_z_q   <= p_z;
			sk_s_q   <= p_s;
			sk_err_q <= p_err;
		end
	end

	assign out_valid = ov_q;

endmodule

>>> src/v3au_checker.sv
`timescale 1ns / 1ps
// v3au_checker: port-level assertions for vector3_arithmetic_unit_core,
// attached by bind. Depends on v3au_pkg.
module v3au_checker import v3au_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t r_x,
	input word_t r_y,
	input word_t r_z,
	input word_t r_scalar,
	input logic  error
);

	// held beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out beat dropped while stalled");

	// held beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(r_x) && $stable(r_y) && $stable(r_z)
			&& $stable(r_scalar) && $stable(error))
		else $error("out payload changed while stalled");

	// input only backs up behind a waiting output beat
	a_ready_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no output pending");

	// divide-by-zero beats carry all-zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> r_x == '0 && r_y == '0 && r_z == '0 && r_scalar == '0)
		else $error("error beat with nonzero result");

endmodule

bind vector3_arithmetic_unit_core v3au_checker u_v3au_checker (.*);
